// File: design/lcwc_pkg.sv
// Package for the load-cell weight conditioning block: field widths,
// register indexes, sequencer states and the job/result structs.
// No dependencies; imported by lcwc_engine and load_cell_weight_conditioning.
package lcwc_pkg;

	localparam int CODE_W  = 24;
	localparam int DIV_W   = 16;
	localparam int ALPHA_W = 17;
	localparam int FRAC_W  = 16;
	localparam int Z_W     = CODE_W + FRAC_W;
	localparam int DIFF_W  = Z_W + 1;
	localparam int ACC_W   = ALPHA_W + Z_W + 1;
	localparam int CNT_W   = 5;
	localparam int CFG_IDX_W = 3;

	localparam logic [CODE_W-1:0]  SIGN_FLIP   = 24'h800000;
	localparam logic [DIV_W-1:0]   DIV0_RESET  = 16'd100;
	localparam logic [DIV_W-1:0]   DIV1_RESET  = 16'd72;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
	localparam logic [CNT_W-1:0]   DIV_STEPS   = 5'd24;
	localparam logic [CNT_W-1:0]   MUL_STEPS   = 5'd17;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FLOOR0 = 3'd0,
		REG_FLOOR1 = 3'd1,
		REG_DIV0   = 3'd2,
		REG_DIV1   = 3'd3,
		REG_TARE0  = 3'd4,
		REG_TARE1  = 3'd5,
		REG_ALPHA0 = 3'd6,
		REG_ALPHA1 = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		E_IDLE,
		E_DIV,
		E_NET,
		E_DIFF,
		E_MUL,
		E_SUM,
		E_DONE
	} eng_state_t;

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [DIV_W-1:0]   divisor;
		logic [CODE_W-1:0]  tare;
		logic [ALPHA_W-1:0] alpha;
		logic [Z_W-1:0]     z;
	} lcwc_job_t;

	typedef struct packed {
		logic [CODE_W-1:0] scaled;
		logic [CODE_W-1:0] net;
		logic [Z_W-1:0]    z;
	} lcwc_res_t;

endpackage

// File: design/lcwc_engine.sv
// Sequenced arithmetic engine: restoring divide, tare clamp and low-pass
// update, all through one shared add/subtract unit.
// Depends on lcwc_pkg.
module lcwc_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  lcwc_pkg::lcwc_job_t job,
	input  logic               ack,
	output logic               done,
	output lcwc_pkg::lcwc_res_t res
);
	import lcwc_pkg::*;

	eng_state_t state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [CODE_W-1:0]  quo_q;
	logic [DIV_W-1:0]   rem_q;
	logic [DIV_W-1:0]   div_q;
	logic [CODE_W-1:0]  tare_q;
	logic [CODE_W-1:0]  net_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [Z_W-1:0]     z_q;
	logic [DIFF_W-1:0]  d_q;
	logic [ACC_W-1:0]   acc_q;

	logic [ACC_W-1:0] add_a, add_b, add_sum;
	logic             add_sub;
	logic             neg;

	// shared adder: subtract by adding the inverted operand plus one
	assign add_sum = add_a + (add_b ^ {ACC_W{add_sub}}) + ACC_W'(add_sub);
	assign neg     = add_sum[ACC_W-1];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			E_IDLE: if (start) state_d = E_DIV;
			E_DIV:  if (cnt_q == '0) state_d = E_NET;
			E_NET:  state_d = E_DIFF;
			E_DIFF: state_d = E_MUL;
			E_MUL:  if (cnt_q == '0) state_d = E_SUM;
			E_SUM:  state_d = E_DONE;
			E_DONE: if (ack) state_d = E_IDLE;
			default: state_d = E_IDLE;
		endcase
	end

	// adder operand select and status
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		done    = 1'b0;
		case (state_q)
			E_DIV: begin
				add_a   = ACC_W'({rem_q, quo_q[CODE_W-1]});
				add_b   = ACC_W'(div_q);
				add_sub = 1'b1;
			end
			E_NET: begin
				add_a   = ACC_W'(quo_q);
				add_b   = ACC_W'(tare_q);
				add_sub = 1'b1;
			end
			E_DIFF: begin
				add_a   = ACC_W'({net_q, {FRAC_W{1'b0}}});
				add_b   = ACC_W'(z_q);
				add_sub = 1'b1;
			end
			E_MUL: begin
				add_a = {acc_q[ACC_W-2:0], 1'b0};
				add_b = alpha_q[ALPHA_W-1] ? {{(ACC_W-DIFF_W){d_q[DIFF_W-1]}}, d_q} : '0;
			end
			E_SUM: begin
				add_a = ACC_W'(z_q);
				add_b = {{FRAC_W{acc_q[ACC_W-1]}}, acc_q[ACC_W-1:FRAC_W]};
			end
			E_DONE: done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				E_IDLE: if (start) cnt_q <= DIV_STEPS - 1'b1;
				E_DIV:  cnt_q <= (cnt_q == '0) ? MUL_STEPS - 1'b1 : cnt_q - 1'b1;
				E_MUL:  cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	// datapath registers, advanced per sequencer step
	always_ff @(posedge clk) begin
		case (state_q)
			E_IDLE: if (start) begin
				quo_q   <= job.code;
				rem_q   <= '0;
				div_q   <= job.divisor;
				tare_q  <= job.tare;
				alpha_q <= job.alpha[ALPHA_W-1] ? ALPHA_ONE : job.alpha;
				z_q     <= job.z;
			end
			E_DIV: begin
				// keep the trial difference when it does not go negative
				if (!neg) begin
					rem_q <= add_sum[DIV_W-1:0];
					quo_q <= {quo_q[CODE_W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DIV_W-2:0], quo_q[CODE_W-1]};
					quo_q <= {quo_q[CODE_W-2:0], 1'b0};
				end
			end
			E_NET: net_q <= neg ? '0 : add_sum[CODE_W-1:0];
			E_DIFF: begin
				d_q   <= add_sum[DIFF_W-1:0];
				acc_q <= '0;
			end
			E_MUL: begin
				acc_q   <= add_sum;
				alpha_q <= {alpha_q[ALPHA_W-2:0], 1'b0};
			end
			E_SUM: z_q <= add_sum[Z_W-1:0];
			default: ;
		endcase
	end

	assign res.scaled = quo_q;
	assign res.net    = net_q;
	assign res.z      = z_q;

endmodule

// File: design/load_cell_weight_conditioning.sv
// Two-channel load-cell conditioning: each beat in carries a channel and a raw
// 24-bit converter word and gives one beat out with the offset code, the held
// flag, the weight in grams, the tared weight and the low-pass value in Q16.
// One sample is worked at a time through a shared adder under a sequencer:
// restoring divide, a tare step, a filter difference step, shift-add
// multiply and a filter sum step. The next sample is taken only once the
// last result has moved into the output register. A finished result
// waits in the output register while the next sample is accepted.
// Configuration writes are taken in every cycle and must only be issued
// while the block is idle.
// Depends on lcwc_pkg and lcwc_engine.
module load_cell_weight_conditioning (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lcwc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lcwc_pkg::CODE_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              channel,
	input  logic [lcwc_pkg::CODE_W-1:0]       raw_word,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              out_channel,
	output logic [lcwc_pkg::CODE_W-1:0]       offset_code,
	output logic                              held,
	output logic [lcwc_pkg::CODE_W-1:0]       scaled_weight,
	output logic [lcwc_pkg::CODE_W-1:0]       net_weight,
	output logic [lcwc_pkg::Z_W-1:0]          filtered_weight
);
	import lcwc_pkg::*;

	logic [CODE_W-1:0]  floor_q [2];
	logic [DIV_W-1:0]   div_q   [2];
	logic [CODE_W-1:0]  tare_q  [2];
	logic [ALPHA_W-1:0] alpha_q [2];
	logic [CODE_W-1:0]  last_code_q [2];
	logic [Z_W-1:0]     filt_q  [2];

	logic              busy_q;
	logic              ch_q;
	logic [CODE_W-1:0] code_q;
	logic              held_q;

	logic              accept, load_out;
	logic [CODE_W-1:0] code;
	logic              reject;
	lcwc_job_t         job;
	lcwc_res_t         res;
	logic              eng_done;

	assign cfg_ready = 1'b1;
	assign in_ready  = !busy_q;
	assign accept    = in_valid && in_ready;
	assign load_out  = eng_done && (!out_valid || out_ready);

	// offset code and floor check
	assign code   = raw_word ^ SIGN_FLIP;
	assign reject = code <= floor_q[channel];

	always_comb begin
		job.code    = reject ? last_code_q[channel] : code;
		job.divisor = div_q[channel];
		job.tare    = tare_q[channel];
		job.alpha   = alpha_q[channel];
		job.z       = filt_q[channel];
	end

	lcwc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.job    (job),
		.ack    (load_out),
		.done   (eng_done),
		.res    (res)
	);

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q[0] <= '0;
			floor_q[1] <= '0;
			div_q[0]   <= DIV0_RESET;
			div_q[1]   <= DIV1_RESET;
			tare_q[0]  <= '0;
			tare_q[1]  <= '0;
			alpha_q[0] <= ALPHA_ONE;
			alpha_q[1] <= ALPHA_ONE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_FLOOR0: floor_q[0] <= cfg_data;
				REG_FLOOR1: floor_q[1] <= cfg_data;
				REG_DIV0:   div_q[0]   <= cfg_data[DIV_W-1:0];
				REG_DIV1:   div_q[1]   <= cfg_data[DIV_W-1:0];
				REG_TARE0:  tare_q[0]  <= cfg_data;
				REG_TARE1:  tare_q[1]  <= cfg_data;
				REG_ALPHA0: alpha_q[0] <= cfg_data[ALPHA_W-1:0];
				REG_ALPHA1: alpha_q[1] <= cfg_data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// per-channel history and the busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			last_code_q[0] <= '0;
			last_code_q[1] <= '0;
			filt_q[0]      <= '0;
			filt_q[1]      <= '0;
		end else begin
			if (accept) begin
				busy_q               <= 1'b1;
				last_code_q[channel] <= job.code;
			end else if (load_out) begin
				busy_q <= 1'b0;
			end
			if (load_out) filt_q[ch_q] <= res.z;
		end
	end

	// hold the sample's side fields until the result is ready
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q   <= channel;
			code_q <= code;
			held_q <= reject;
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_channel     <= ch_q;
			offset_code     <= code_q;
			held            <= held_q;
			scaled_weight   <= res.scaled;
			net_weight      <= res.net;
			filtered_weight <= res.z;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && !in_ready)
		else $error("block not busy after accepting a beat");

	a_load_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> busy_q)
		else $error("result loaded with no sample in flight");

	a_idle_engine_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !eng_done)
		else $error("engine reports done while block is idle");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid && !busy_q)
		else $error("result load did not present a beat");

endmodule

// File: tb/tb_load_cell_weight_conditioning.sv
// Self-checking testbench for load_cell_weight_conditioning: a predictor class
// tracks floor, divide, tare and low-pass per channel and checks every beat out.
// Depends on lcwc_pkg and the design files; needs no input files.
`timescale 1ns / 1ps

module tb_load_cell_weight_conditioning;
	import lcwc_pkg::*;

	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int PHASES         = 8;
	localparam int PHASE_SAMPLES  = 210;

	typedef struct {
		logic              ch;
		logic [CODE_W-1:0] code;
		logic              held;
		logic [CODE_W-1:0] scaled;
		logic [CODE_W-1:0] net;
		logic [Z_W-1:0]    filt;
	} weight_result_t;

	// Per-channel predictor of the conditioning chain and queue of pending weights
	class weight_scoreboard;
		logic [CODE_W-1:0]  floor_code[2];
		logic [DIV_W-1:0]   divisor[2];
		logic [CODE_W-1:0]  tare[2];
		logic [ALPHA_W-1:0] alpha[2];
		logic [CODE_W-1:0]  last_code[2];
		logic [Z_W-1:0]     filt_z[2];
		weight_result_t     pending_weights[$];
		int errors, samples, checked, held_cnt, clamp_cnt, zero_div_cnt;

		function new();
			floor_code = '{default: '0};
			divisor    = '{DIV0_RESET, DIV1_RESET};
			tare       = '{default: '0};
			alpha      = '{ALPHA_ONE, ALPHA_ONE};
			last_code  = '{default: '0};
			filt_z     = '{default: '0};
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CODE_W-1:0] data);
			case (idx)
				REG_FLOOR0: floor_code[0] = data;
				REG_FLOOR1: floor_code[1] = data;
				REG_DIV0:   divisor[0] = data[DIV_W-1:0];
				REG_DIV1:   divisor[1] = data[DIV_W-1:0];
				REG_TARE0:  tare[0] = data;
				REG_TARE1:  tare[1] = data;
				REG_ALPHA0: alpha[0] = data[ALPHA_W-1:0];
				REG_ALPHA1: alpha[1] = data[ALPHA_W-1:0];
				default: ;
			endcase
		endfunction

		// Work out the weight one accepted sample must produce
		function void note_sample(logic ch, logic [CODE_W-1:0] raw);
			weight_result_t r;
			logic [CODE_W-1:0] used;
			longint a, z, t, p;
			r.ch = ch;
			r.code = raw ^ SIGN_FLIP;
			r.held = (r.code <= floor_code[ch]);
			used = r.held ? last_code[ch] : r.code;
			last_code[ch] = used;
			if (divisor[ch] == 0) begin
				r.scaled = '1;
				zero_div_cnt++;
			end else begin
				r.scaled = used / divisor[ch];
			end
			if (tare[ch] >= r.scaled) begin
				r.net = '0;
				if (r.scaled != 0) clamp_cnt++;
			end else begin
				r.net = r.scaled - tare[ch];
			end
			// Coefficients above one act as one
			a = (alpha[ch] > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha[ch]);
			z = longint'(filt_z[ch]);
			t = longint'({r.net, 16'h0000});
			p = a * (t - z);
			z = z + (p >>> FRAC_W);
			filt_z[ch] = z[Z_W-1:0];
			r.filt = filt_z[ch];
			if (r.held) held_cnt++;
			samples++;
			pending_weights.push_back(r);
		endfunction

		function bit field_ok(string name, logic [Z_W-1:0] want, logic [Z_W-1:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
					$time, name, want, got);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		// Compare one beat out with the oldest pending weight
		function void check_result(weight_result_t got);
			weight_result_t want;
			bit ok;
			if (pending_weights.size() == 0) begin
				$display("%0t: unexpected beat out, expected none actual ch %0d code 0x%0h",
					$time, got.ch, got.code);
				errors++;
				return;
			end
			want = pending_weights.pop_front();
			ok = field_ok("out_channel", want.ch, got.ch);
			ok &= field_ok("offset_code", want.code, got.code);
			ok &= field_ok("held", want.held, got.held);
			ok &= field_ok("scaled_weight", want.scaled, got.scaled);
			ok &= field_ok("net_weight", want.net, got.net);
			ok &= field_ok("filtered_weight", want.filt, got.filt);
			if (!ok) errors++;
			checked++;
		endfunction

		function int pending();
			return pending_weights.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	cfg_idx_t          cfg_index = REG_FLOOR0;
	logic [CODE_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              channel = 1'b0;
	logic [CODE_W-1:0] raw_word = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              out_channel;
	logic [CODE_W-1:0] offset_code;
	logic              held;
	logic [CODE_W-1:0] scaled_weight;
	logic [CODE_W-1:0] net_weight;
	logic [Z_W-1:0]    filtered_weight;

	weight_scoreboard sb = new();
	logic [CODE_W-1:0] cfg_vals[8];
	int send_idle_pct = 0;
	int rcv_stall_pct = 0;
	int hold_requests = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int settings_cnt = 0;

	load_cell_weight_conditioning dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.channel        (channel),
		.raw_word       (raw_word),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_channel    (out_channel),
		.offset_code    (offset_code),
		.held           (held),
		.scaled_weight  (scaled_weight),
		.net_weight     (net_weight),
		.filtered_weight(filtered_weight)
	);

	always #5 clk = ~clk;

	// Receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	// Check every beat out
	always @(posedge clk) begin
		weight_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.ch = out_channel;
			got.code = offset_code;
			got.held = held;
			got.scaled = scaled_weight;
			got.net = net_weight;
			got.filt = filtered_weight;
			sb.check_result(got);
		end
	end

	// Watchdog: end the run when no channel moves a beat for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one sample, idling first at the current sender rate
	task automatic send_sample(logic ch, logic [CODE_W-1:0] raw);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (send_idle_pct != 0 && $urandom_range(7) == 0) gap += $urandom_range(60);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		channel <= ch;
		raw_word <= raw;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(ch, raw);
	endtask

	// Random sample, often placed on or just above the channel floor
	task automatic send_random_sample();
		logic ch;
		logic [CODE_W-1:0] flr, code;
		ch = 1'($urandom);
		flr = cfg_vals[int'(REG_FLOOR0) + ch];
		case ($urandom_range(9))
			0: code = flr;
			1: code = flr + 24'd1;
			2: code = flr + 24'($urandom_range(255));
			default: code = 24'($urandom);
		endcase
		send_sample(ch, code ^ SIGN_FLIP);
	endtask

	// Stop offering and wait until every pending weight has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all eight registers back to back; only call while idle
	task automatic set_and_write(logic [CODE_W-1:0] f0, f1, d0, d1, t0, t1, a0, a1);
		cfg_vals = '{f0, f1, d0, d1, t0, t1, a0, a1};
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= cfg_vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(cfg_idx_t'(i), cfg_vals[i]);
		end
		cfg_valid <= 1'b0;
		settings_cnt++;
	endtask

	// Draw a random setting per channel, unused upper data bits included
	task automatic pick_settings();
		logic [CODE_W-1:0] f[2], d[2], t[2], a[2];
		logic [DIV_W-1:0] dv;
		int top;
		for (int c = 0; c < 2; c++) begin
			case ($urandom_range(3))
				0: f[c] = '0;
				1: f[c] = 24'($urandom_range(24'h3FFFFF));
				2: f[c] = 24'($urandom);
				default: f[c] = 24'h7FFFFF;
			endcase
			case ($urandom_range(4))
				0: dv = 16'($urandom_range(255, 1));
				1: dv = 16'($urandom_range(65535, 1));
				2: dv = 16'd1;
				3: dv = 16'hFFFF;
				default: dv = '0;
			endcase
			d[c] = {8'($urandom), dv};
			top = (dv == 0) ? 24'hFFFFFF : 24'hFFFFFF / dv;
			t[c] = ($urandom_range(2) == 0) ? '0 : 24'($urandom_range(top));
			case ($urandom_range(3))
				0: a[c] = {7'($urandom), ALPHA_ONE};
				1: a[c] = {7'($urandom), 17'($urandom_range(65535, 1))};
				2: a[c] = {7'($urandom), 17'($urandom_range(1023))};
				default: a[c] = {7'($urandom), 17'($urandom_range(131071, 65537))};
			endcase
		end
		set_and_write(f[0], f[1], d[0], d[1], t[0], t[1], a[0], a[1]);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: code extremes and rejection at a zero floor
		cfg_vals = '{24'h0, 24'h0, 24'd100, 24'd72, 24'h0, 24'h0, 24'h10000, 24'h10000};
		send_sample(1'b0, 24'h000000);
		send_sample(1'b0, 24'h7FFFFF);
		send_sample(1'b0, 24'h800000);
		send_sample(1'b1, 24'hFFFFFF);
		send_sample(1'b1, 24'h800001);
		send_sample(1'b1, 24'h800000);
		drain();

		// Zero divisor, oversized and zero alpha, everything held on channel 1
		set_and_write(24'h900000, 24'hFFFFFF, 24'hFF0000, 24'h000001,
			24'h000100, 24'hFFFFFF, 24'hFFFFFF, 24'h000000);
		send_sample(1'b0, 24'h100000);
		send_sample(1'b0, 24'h100001);
		send_sample(1'b1, 24'h7FFFFF);
		send_sample(1'b1, 24'h000000);
		drain();

		// Tare equal to the weight, widest divisor, slow and half-rate filters
		set_and_write(24'h000000, 24'h000000, 24'hFFFFFF, 24'h000001,
			24'h000000, 24'h123456, 24'h000001, 24'h008000);
		send_sample(1'b1, 24'h123456 ^ SIGN_FLIP);
		send_sample(1'b1, 24'h123457 ^ SIGN_FLIP);
		send_sample(1'b1, 24'hFFFFFF ^ SIGN_FLIP);
		send_sample(1'b1, 24'hFFFFFF ^ SIGN_FLIP);
		send_sample(1'b0, 24'hFFFFFF ^ SIGN_FLIP);
		send_sample(1'b0, 24'hFFFFFF ^ SIGN_FLIP);
		send_sample(1'b1, 24'h000001 ^ SIGN_FLIP);
		send_sample(1'b1, 24'h000002 ^ SIGN_FLIP);
		send_sample(1'b0, 24'h000001 ^ SIGN_FLIP);
		drain();

		// Random phases, each with its own settings and idling pattern
		for (int ph = 0; ph < PHASES; ph++) begin
			pick_settings();
			case (ph % 4)
				0: begin send_idle_pct = 0;  rcv_stall_pct <= 0;  end
				1: begin send_idle_pct = 68; rcv_stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  rcv_stall_pct <= 68; end
				default: begin send_idle_pct = 9; rcv_stall_pct <= 9; end
			endcase
			for (int n = 0; n < PHASE_SAMPLES; n++) begin
				// Hold the output off while samples keep coming, to back up the input
				if (ph == 0 && n == 100) hold_requests <= hold_requests + 1;
				send_random_sample();
			end
			drain();
		end

		repeat (64) @(posedge clk);
		$display("summary: %0d samples over %0d settings, %0d weights checked",
			sb.samples, settings_cnt, sb.checked);
		$display("summary: %0d held, %0d clamped by tare, %0d with zero divisor",
			sb.held_cnt, sb.clamp_cnt, sb.zero_div_cnt);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("%0t: %0d mismatches, %0d weights never came out",
				$time, sb.errors, sb.pending());
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: load_cell_weight_conditioning.f
design/lcwc_pkg.sv
design/lcwc_engine.sv
design/load_cell_weight_conditioning.sv
tb/tb_load_cell_weight_conditioning.sv
